@@ sv/adll_pkg.sv @@
// shared types and constants of the array doubly linked list
package adll_pkg;

  localparam int unsigned FIELD_W     = 10;
  localparam int unsigned NODE_COUNT  = 1024;
  localparam int unsigned VALUE_COUNT = 1024;

  // highest node index the allocator may hand out
  localparam logic [FIELD_W-1:0] LAST_MAX  = FIELD_W'(NODE_COUNT - 1);
  // map entries are valid below this bound
  localparam logic [FIELD_W:0]   VALUE_LIM = (FIELD_W + 1)'(VALUE_COUNT);
  localparam logic [FIELD_W-1:0] CLR_LAST  = FIELD_W'(VALUE_COUNT - 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_INS_AFTER   = 3'd1,
    OP_INS_BEFORE  = 3'd2,
    OP_ERASE       = 3'd3,
    OP_FIND        = 3'd4,
    OP_READ        = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_INVALID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_DONE
  } state_e;

endpackage

@@ sv/array_doubly_linked_list.sv @@
// doubly linked list held in node memories, driven by a small sequencer
//
// usage:
//   input items arrive on the s_axis channel, each one an operation code, a node
//   position and a value; every accepted item gives exactly one result item on the
//   m_axis channel (status, node index, node value and both links of a read node)
//   node 0 is the head sentinel, new nodes come from a rising allocation counter
// timing:
//   an insert that allocates a node passes execute, second link write and hand-off
//   before its result is in the output register; reads, finds, erases and rejected
//   items skip the link write; a new item is taken only once the previous one has
//   handed off its result to the output register, so a held output register also
//   holds off s_axis_tready
//   the sequencer works on one item at a time since each item reads and then writes
//   the single-port link memories; s_axis_tready is high only while it is idle
// reset:
//   after rst_ni releases, a clearing pass zeroes the value-to-node map one entry a
//   cycle; no item is accepted meanwhile
// stalls:
//   a result waits in the output register until m_axis_tready; the next item may be
//   accepted meanwhile, and its result is held back until the register is free
module array_doubly_linked_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] operation, [12:3] position, [22:13] item_value, [23] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [11:2] node_index, [21:12] node_value, [31:22] next_node,
  // [41:32] prev_node, [47:42] zero
  output logic [47:0] m_axis_tdata
);
  import adll_pkg::*;

  typedef logic [FIELD_W-1:0] idx_t;

  // node memories and the value-to-node map
  idx_t nv_mem  [NODE_COUNT];
  idx_t nx_mem  [NODE_COUNT];
  idx_t pv_mem  [NODE_COUNT];
  idx_t map_mem [VALUE_COUNT];

  state_e state_q, state_d;

  // latched input item
  logic [2:0] op_q;
  idx_t       pos_q, val_q;

  // registered memory read data, taken at acceptance
  idx_t rd_nv_q, rd_nx_q, rd_pv_q, rd_map_q;
  logic rd_zero_q;

  // head sentinel links live in flops, memory entry 0 is never trusted
  idx_t head_nx_q, head_nx_d, head_pv_q, head_pv_d;

  idx_t last_q, last_d;
  idx_t clr_cnt_q;

  // pending second link write of an insert
  idx_t link_a_q, link_b_q, new_q;
  idx_t link_a_d, link_b_d;

  // result waiting for the output register
  status_e res_sts_q, res_sts_d;
  idx_t    res_idx_q, res_idx_d, res_val_q, res_val_d;
  idx_t    res_nx_q, res_nx_d, res_pv_q, res_pv_d;

  logic        out_valid_q, out_valid_d;
  logic [47:0] out_data_q;

  // memory write ports
  logic nv_we, nx_we, pv_we, map_we;
  idx_t nv_waddr, nv_wdata, nx_waddr, nx_wdata;
  idx_t pv_waddr, pv_wdata, map_waddr, map_wdata;

  logic accept, out_load;
  op_e  in_op;
  idx_t in_pos, in_val, rd_addr;

  idx_t cur_nx, cur_pv, new_node;
  logic pos_ok, is_full, pos_head;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_op  = op_e'(s_axis_tdata[2:0]);
  assign in_pos = s_axis_tdata[12:3];
  assign in_val = s_axis_tdata[22:13];
  // push front works on the head, so its links are read instead of the position's
  assign rd_addr = (in_op == OP_PUSH_FRONT) ? '0 : in_pos;

  assign cur_nx   = rd_zero_q ? head_nx_q : rd_nx_q;
  assign cur_pv   = rd_zero_q ? head_pv_q : rd_pv_q;
  assign new_node = last_q + idx_t'(1);
  assign pos_ok   = (pos_q <= last_q);
  assign is_full  = (last_q == LAST_MAX);
  assign pos_head = (pos_q == '0);

  // sequencer: next state, memory writes and result
  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    link_a_d  = link_a_q;
    link_b_d  = link_b_q;
    res_sts_d = res_sts_q;
    res_idx_d = res_idx_q;
    res_val_d = res_val_q;
    res_nx_d  = res_nx_q;
    res_pv_d  = res_pv_q;
    out_load  = 1'b0;
    nv_we     = 1'b0;
    nv_waddr  = new_node;
    nv_wdata  = val_q;
    nx_we     = 1'b0;
    nx_waddr  = new_node;
    nx_wdata  = '0;
    pv_we     = 1'b0;
    pv_waddr  = new_node;
    pv_wdata  = '0;
    map_we    = 1'b0;
    map_waddr = val_q;
    map_wdata = new_node;

    unique case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt_q;
        map_wdata = '0;
        if (clr_cnt_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_sts_d = STS_OK;
        res_idx_d = '0;
        res_val_d = '0;
        res_nx_d  = '0;
        res_pv_d  = '0;
        state_d   = S_DONE;
        // neighbors of the new or erased node
        case (op_q)
          OP_PUSH_FRONT: begin
            link_a_d = '0;
            link_b_d = cur_nx;
          end
          OP_INS_AFTER: begin
            link_a_d = pos_q;
            link_b_d = cur_nx;
          end
          default: begin
            link_a_d = cur_pv;
            link_b_d = (op_q == OP_ERASE) ? cur_nx : pos_q;
          end
        endcase
        case (op_q) inside
          OP_PUSH_FRONT, OP_INS_AFTER, OP_INS_BEFORE: begin
            // push front ignores the position field
            if ((op_q != OP_PUSH_FRONT && !pos_ok) ||
                (op_q == OP_INS_BEFORE && pos_head)) begin
              res_sts_d = STS_INVALID;
            end else if (is_full) begin
              res_sts_d = STS_FULL;
            end else begin
              // new node gets its value, both links and its map entry
              res_idx_d = new_node;
              last_d    = new_node;
              nv_we     = 1'b1;
              nx_we     = 1'b1;
              nx_wdata  = link_b_d;
              pv_we     = 1'b1;
              pv_wdata  = link_a_d;
              map_we    = ({1'b0, val_q} < VALUE_LIM);
              state_d   = S_LINK;
            end
          end
          OP_ERASE: begin
            if (!pos_ok || pos_head) begin
              res_sts_d = STS_INVALID;
            end else begin
              // unlink both ways, back link only when a successor exists
              nx_we     = 1'b1;
              nx_waddr  = cur_pv;
              nx_wdata  = cur_nx;
              pv_we     = (cur_nx != '0);
              pv_waddr  = cur_nx;
              pv_wdata  = cur_pv;
              map_we    = ({1'b0, rd_nv_q} < VALUE_LIM);
              map_waddr = rd_nv_q;
              map_wdata = '0;
            end
          end
          OP_FIND: begin
            res_idx_d = ({1'b0, val_q} < VALUE_LIM) ? rd_map_q : '0;
          end
          OP_READ: begin
            if (!pos_ok) begin
              res_sts_d = STS_INVALID;
            end else begin
              res_val_d = pos_head ? '0 : rd_nv_q;
              res_nx_d  = cur_nx;
              res_pv_d  = cur_pv;
            end
          end
          default: begin
            res_sts_d = STS_INVALID;
          end
        endcase
      end
      S_LINK: begin
        // neighbors now point at the new node
        nx_we    = 1'b1;
        nx_waddr = link_a_q;
        nx_wdata = new_q;
        pv_we    = 1'b1;
        pv_waddr = link_b_q;
        pv_wdata = new_q;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    head_nx_d = (nx_we && nx_waddr == '0) ? nx_wdata : head_nx_q;
    head_pv_d = (pv_we && pv_waddr == '0) ? pv_wdata : head_pv_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      last_q      <= '0;
      head_nx_q   <= '0;
      head_pv_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      head_nx_q   <= head_nx_d;
      head_pv_q   <= head_pv_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + idx_t'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= s_axis_tdata[2:0];
      pos_q     <= in_pos;
      val_q     <= in_val;
      rd_nv_q   <= nv_mem[rd_addr];
      rd_nx_q   <= nx_mem[rd_addr];
      rd_pv_q   <= pv_mem[rd_addr];
      rd_map_q  <= map_mem[in_val];
      rd_zero_q <= (rd_addr == '0);
    end
    if (state_q == S_EXEC) begin
      link_a_q <= link_a_d;
      link_b_q <= link_b_d;
      new_q    <= new_node;
    end
    res_sts_q <= res_sts_d;
    res_idx_q <= res_idx_d;
    res_val_q <= res_val_d;
    res_nx_q  <= res_nx_d;
    res_pv_q  <= res_pv_d;
    if (out_load) begin
      out_data_q <= {6'd0, res_pv_q, res_nx_q, res_val_q, res_idx_q, res_sts_q};
    end
  end

  // memory write ports
  always_ff @(posedge clk_i) begin
    if (nv_we) begin
      nv_mem[nv_waddr] <= nv_wdata;
    end
    if (nx_we) begin
      nx_mem[nx_waddr] <= nx_wdata;
    end
    if (pv_we) begin
      pv_mem[pv_waddr] <= pv_wdata;
    end
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_last_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q <= LAST_MAX)
    else $error("allocation counter beyond node store");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == S_IDLE) && (clr_cnt_q == '0))
    else $error("item accepted while busy or clearing");

  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> (last_q == new_q) && (new_q != '0))
    else $error("insert did not advance the allocation counter");

  a_alloc_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_q != $past(last_q)) |-> ($past(state_q) == S_EXEC) && (state_q == S_LINK))
    else $error("allocation counter moved outside an insert");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !m_axis_tready) |=> (state_q == S_DONE))
    else $error("result overwrote a pending output");
`endif

endmodule

@@ verif/array_doubly_linked_list_tb.sv @@
// self-checking testbench of the array doubly linked list: directed and random items
module array_doubly_linked_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adll_pkg::*;

  // codes outside the operation set, rejected by the block
  localparam logic [2:0] OP_UNDEF_A = 3'd6;
  localparam logic [2:0] OP_UNDEF_B = 3'd7;

  localparam int unsigned DRAIN_CYCLES = 8;      // margin past the slowest item's result
  localparam int unsigned CYCLE_LIMIT  = 200000; // clearing pass plus slowest item flow, many times
  localparam int unsigned PHASE_ITEMS  = 487;

  typedef struct {
    status_e            status;
    logic [FIELD_W-1:0] node_index;
    logic [FIELD_W-1:0] node_value;
    logic [FIELD_W-1:0] next_node;
    logic [FIELD_W-1:0] prev_node;
  } list_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  array_doubly_linked_list uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predicted copy of the list memories
  logic [FIELD_W-1:0] node_val_q [NODE_COUNT];
  logic [FIELD_W-1:0] next_q     [NODE_COUNT];
  logic [FIELD_W-1:0] prev_q     [NODE_COUNT];
  logic [FIELD_W-1:0] map_q      [VALUE_COUNT];
  logic [FIELD_W-1:0] last_alloc_q;

  list_result_t pending_results [$];
  int unsigned  fail_count;
  int unsigned  cycle_count;
  int unsigned  send_idle_pct;
  int unsigned  rcv_stall_pct;

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // run limit, also covers a hang while draining
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // allocate a node holding val between nodes a and b
  function automatic logic [FIELD_W-1:0] link_node(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                                   logic [FIELD_W-1:0] val);
    logic [FIELD_W-1:0] n;
    n = last_alloc_q + 1'b1;
    last_alloc_q = n;
    node_val_q[n] = val;
    if (val < VALUE_COUNT) map_q[val] = n;
    prev_q[n] = a;
    next_q[n] = b;
    prev_q[b] = n;
    next_q[a] = n;
    return n;
  endfunction

  // work out the result of one operation and update the predicted list
  function automatic list_result_t apply_list_op(logic [2:0] op, logic [FIELD_W-1:0] pos,
                                                 logic [FIELD_W-1:0] val);
    list_result_t       r;
    logic               pos_ok;
    logic               store_full;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    r.status     = STS_OK;
    r.node_index = '0;
    r.node_value = '0;
    r.next_node  = '0;
    r.prev_node  = '0;
    pos_ok       = (pos <= last_alloc_q);
    store_full   = (last_alloc_q == LAST_MAX);
    case (op)
      OP_PUSH_FRONT: begin
        if (store_full) r.status = STS_FULL;
        else r.node_index = link_node('0, next_q[0], val);
      end
      OP_INS_AFTER: begin
        if (!pos_ok) r.status = STS_INVALID;
        else if (store_full) r.status = STS_FULL;
        else r.node_index = link_node(pos, next_q[pos], val);
      end
      OP_INS_BEFORE: begin
        if (!pos_ok || pos == 0) r.status = STS_INVALID;
        else if (store_full) r.status = STS_FULL;
        else r.node_index = link_node(prev_q[pos], pos, val);
      end
      OP_ERASE: begin
        if (!pos_ok || pos == 0) begin
          r.status = STS_INVALID;
        end else begin
          // unlink both ways; the erased node keeps its own stale links
          a = prev_q[pos];
          b = next_q[pos];
          next_q[a] = b;
          if (b != 0) prev_q[b] = a;
          if (node_val_q[pos] < VALUE_COUNT) map_q[node_val_q[pos]] = '0;
        end
      end
      OP_FIND: begin
        r.node_index = (val < VALUE_COUNT) ? map_q[val] : '0;
      end
      OP_READ: begin
        if (!pos_ok) begin
          r.status = STS_INVALID;
        end else begin
          r.node_value = (pos == 0) ? '0 : node_val_q[pos];
          r.next_node  = next_q[pos];
          r.prev_node  = prev_q[pos];
        end
      end
      default: r.status = STS_INVALID;
    endcase
    return r;
  endfunction

  // send one item, predict its result once it is accepted
  task automatic send_item(logic [2:0] op, logic [FIELD_W-1:0] pos, logic [FIELD_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, val, pos, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_list_op(op, pos, val));
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic bit field_ok(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    bit           ok;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status     = status_e'(m_axis_tdata[1:0]);
      got.node_index = m_axis_tdata[11:2];
      got.node_value = m_axis_tdata[21:12];
      got.next_node  = m_axis_tdata[31:22];
      got.prev_node  = m_axis_tdata[41:32];
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        ok = field_ok("status", FIELD_W'(want.status), FIELD_W'(got.status));
        ok &= field_ok("node_index", want.node_index, got.node_index);
        ok &= field_ok("node_value", want.node_value, got.node_value);
        ok &= field_ok("next_node", want.next_node, got.next_node);
        ok &= field_ok("prev_node", want.prev_node, got.prev_node);
        if (!ok) fail_count++;
      end
    end
  end

  // mostly an allocated node, sometimes anything the field allows
  function automatic logic [FIELD_W-1:0] pick_position(bit nonzero);
    if ($urandom_range(0, 99) < 8) return FIELD_W'($urandom_range(0, 1023));
    if (nonzero && last_alloc_q != 0) return FIELD_W'($urandom_range(1, last_alloc_q));
    return FIELD_W'($urandom_range(0, last_alloc_q));
  endfunction

  // narrow values collide in the map, stored values make finds hit
  function automatic logic [FIELD_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return FIELD_W'($urandom_range(0, 1023));
    if (r < 80 || last_alloc_q == 0) return FIELD_W'($urandom_range(0, 15));
    return node_val_q[$urandom_range(1, last_alloc_q)];
  endfunction

  // empty list: head reads, head rejects, unallocated positions, undefined codes
  task automatic test_empty_list();
    send_item(OP_READ, 10'd0, 10'd0);
    send_item(OP_FIND, 10'd0, 10'd5);
    send_item(OP_ERASE, 10'd0, 10'd0);
    send_item(OP_INS_BEFORE, 10'd0, 10'd3);
    send_item(OP_READ, 10'd3, 10'd0);
    send_item(OP_INS_AFTER, 10'd3, 10'd4);
    send_item(OP_ERASE, 10'd1023, 10'd0);
    send_item(OP_UNDEF_A, 10'd0, 10'd1023);
    send_item(OP_UNDEF_B, 10'd1023, 10'd1023);
  endtask

  // every insert kind, including insert after head and at both ends
  task automatic test_link_updates();
    send_item(OP_PUSH_FRONT, 10'd0, 10'd0);
    send_item(OP_PUSH_FRONT, 10'd1023, 10'd1023);
    send_item(OP_INS_AFTER, 10'd1, 10'd7);
    send_item(OP_INS_BEFORE, 10'd1, 10'd9);
    send_item(OP_INS_AFTER, 10'd0, 10'd11);
    send_item(OP_INS_BEFORE, 10'd2, 10'd13);
    send_item(OP_READ, 10'd0, 10'd0);
    send_item(OP_READ, 10'd1, 10'd0);
    send_item(OP_READ, 10'd6, 10'd0);
    send_item(OP_FIND, 10'd0, 10'd1023);
  endtask

  // tail erase, repeated erase on stale links, head-adjacent erase
  task automatic test_erase_cases();
    send_item(OP_ERASE, 10'd3, 10'd0);
    send_item(OP_ERASE, 10'd3, 10'd0);
    send_item(OP_READ, 10'd3, 10'd0);
    send_item(OP_FIND, 10'd0, 10'd7);
    send_item(OP_ERASE, 10'd5, 10'd0);
    send_item(OP_READ, 10'd0, 10'd0);
    send_item(OP_INS_AFTER, 10'd3, 10'd21);
  endtask

  // random mix of operations under one idling setting
  task automatic test_random_traffic(int unsigned send_pct, int unsigned stall_pct);
    int unsigned        r;
    logic [2:0]         op;
    logic [FIELD_W-1:0] pos;
    send_idle_pct = send_pct;
    rcv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 20) op = OP_PUSH_FRONT;
      else if (r < 40) op = OP_INS_AFTER;
      else if (r < 58) op = OP_INS_BEFORE;
      else if (r < 70) op = OP_ERASE;
      else if (r < 82) op = OP_FIND;
      else if (r < 96) op = OP_READ;
      else op = ($urandom_range(0, 1) != 0) ? OP_UNDEF_B : OP_UNDEF_A;
      pos = pick_position(op == OP_INS_BEFORE || op == OP_ERASE);
      send_item(op, pos, pick_value());
    end
    drain_results();
  endtask

  // fill the node store, then every insert is refused; head check comes first
  task automatic test_store_full();
    send_idle_pct = 8;
    rcv_stall_pct = 8;
    while (last_alloc_q != LAST_MAX) send_item(OP_PUSH_FRONT, 10'd0, pick_value());
    send_item(OP_PUSH_FRONT, 10'd0, 10'd1);
    send_item(OP_INS_AFTER, 10'd1023, 10'd2);
    send_item(OP_INS_BEFORE, 10'd512, 10'd3);
    send_item(OP_INS_BEFORE, 10'd0, 10'd4);
    send_item(OP_READ, 10'd1023, 10'd0);
    send_item(OP_FIND, 10'd0, node_val_q[1023]);
    send_item(OP_ERASE, 10'd1023, 10'd0);
    send_item(OP_READ, 10'd0, 10'd0);
    drain_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    last_alloc_q  = '0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      node_val_q[i] = '0;
      next_q[i]     = '0;
      prev_q[i]     = '0;
    end
    for (int i = 0; i < VALUE_COUNT; i++) map_q[i] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the clearing pass after reset simply shows up as a long wait for tready
    test_empty_list();
    test_link_updates();
    test_erase_cases();
    drain_results();

    test_random_traffic(0, 0);
    test_random_traffic(45, 0);
    test_random_traffic(0, 45);
    test_random_traffic(8, 8);
    test_store_full();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
